// ===== sv/clipped_sprite_blitter_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sprite blitter core
// Shorthand for clocked checks that are held off during reset.
// ---------------------------------------------------------------------------
`ifndef CLIPPED_SPRITE_BLITTER_CORE_ASSERT_SVH
`define CLIPPED_SPRITE_BLITTER_CORE_ASSERT_SVH

// same-cycle implication
`define CSB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sprite blitter check failed");

// next-cycle implication
`define CSB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sprite blitter check failed");

`endif

// ===== sv/csb_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sprite blitter package
// Shared widths, register indexes, stage types and size clamping.
// ---------------------------------------------------------------------------
package csb_pkg;

  localparam int PIX_W     = 16;
  localparam int OFS_W     = 12;
  localparam int SIZE_W    = 11;
  localparam int POS_W     = 13;
  localparam int IDX_W     = 11;
  localparam int FWC_W     = 12;
  localparam int PROD_W    = IDX_W + FWC_W;
  localparam int ADDR_W    = 19;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 12;

  localparam logic [PIX_W-1:0] ALPHA_MASK = 16'hF000;

  localparam int DEF_FRAME_W  = 640;
  localparam int DEF_FRAME_H  = 480;
  localparam int DEF_MAX_RECT = 1024;

  localparam logic [SIZE_W-1:0] RESET_SIZE = 11'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEST_X       = 3'd0,
    REG_DEST_Y       = 3'd1,
    REG_RECT_WIDTH   = 3'd2,
    REG_RECT_HEIGHT  = 3'd3,
    REG_ALPHA_ENABLE = 3'd4
  } csb_reg_e;

  typedef struct packed {
    logic signed [OFS_W-1:0] dest_x;
    logic signed [OFS_W-1:0] dest_y;
    logic [SIZE_W-1:0]       rect_width;
    logic [SIZE_W-1:0]       rect_height;
    logic                    alpha_enable;
  } csb_cfg_t;

  typedef struct packed {
    logic                    valid;
    logic [PIX_W-1:0]        pixel;
    logic signed [POS_W-1:0] col;
    logic signed [POS_W-1:0] row;
    logic                    alpha_ok;
    logic                    last;
  } csb_stage_t;

  // last index along one axis: zero size counts as one, clamp at the maximum
  function automatic logic [SIZE_W-1:0] size_limit(input logic [SIZE_W-1:0] s,
                                                   input logic [SIZE_W-1:0] max_m1);
    logic [SIZE_W-1:0] sm1;
    sm1 = s - 1'b1;
    if (s == '0) begin
      return '0;
    end else if (sm1 > max_m1) begin
      return max_m1;
    end else begin
      return sm1;
    end
  endfunction

endpackage

// ===== sv/clipped_sprite_blitter_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Clipped sprite blitter core
// Maps a raster stream of rectangle pixels onto frame addresses with clipping
// and an alpha key.
// ---------------------------------------------------------------------------
// Usage:
//   Source channel (src_valid, src_stall, pixel) carries the rectangle's
//   pixels left to right, top to bottom. Destination channel (dst_valid,
//   dst_stall, write_enable, frame_addr, pixel_out, last) gives one transfer
//   per pixel: the frame address, the pixel, a write enable that is low when
//   the target falls outside the frame or fails the alpha key, and last on
//   the final pixel of the rectangle.
//   From a source transfer to its destination result a pixel passes the input
//   register behind the counters, then the result register behind the
//   address multiply-add. Throughput is one pixel per cycle without stalls.
//   A destination stall holds the result register; the input register still
//   takes one more pixel if it is empty, after which src_stall rises.
//   Reset clears the counters and both valid flags and loads dest 0,0, a 16x16
//   rectangle and the alpha key on. Write the registers through cfg_we,
//   cfg_index and cfg_data only while no pixel is in flight.
// ---------------------------------------------------------------------------
`include "clipped_sprite_blitter_core_assert.svh"

module clipped_sprite_blitter_core import csb_pkg::*; #(
  parameter int FRAME_W  = DEF_FRAME_W,
  parameter int FRAME_H  = DEF_FRAME_H,
  parameter int MAX_RECT = DEF_MAX_RECT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 src_valid,
  output logic                 src_stall,
  input  logic [PIX_W-1:0]     pixel,
  output logic                 dst_valid,
  input  logic                 dst_stall,
  output logic                 write_enable,
  output logic [ADDR_W-1:0]    frame_addr,
  output logic [PIX_W-1:0]     pixel_out,
  output logic                 last
);

  csb_cfg_t   cfg;
  csb_stage_t stage;
  logic       take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dest_x       <= '0;
      cfg.dest_y       <= '0;
      cfg.rect_width   <= RESET_SIZE;
      cfg.rect_height  <= RESET_SIZE;
      cfg.alpha_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (csb_reg_e'(cfg_index))
        REG_DEST_X:       cfg.dest_x       <= cfg_data[OFS_W-1:0];
        REG_DEST_Y:       cfg.dest_y       <= cfg_data[OFS_W-1:0];
        REG_RECT_WIDTH:   cfg.rect_width   <= cfg_data[SIZE_W-1:0];
        REG_RECT_HEIGHT:  cfg.rect_height  <= cfg_data[SIZE_W-1:0];
        REG_ALPHA_ENABLE: cfg.alpha_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  csb_walker #(
    .MAX_RECT (MAX_RECT)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .pixel     (pixel),
    .take      (take),
    .stage     (stage)
  );

  csb_mapper #(
    .FRAME_W (FRAME_W),
    .FRAME_H (FRAME_H)
  ) u_mapper (
    .clk          (clk),
    .rst          (rst),
    .stage        (stage),
    .take         (take),
    .dst_valid    (dst_valid),
    .dst_stall    (dst_stall),
    .write_enable (write_enable),
    .frame_addr   (frame_addr),
    .pixel_out    (pixel_out),
    .last         (last)
  );

  `CSB_ASSERT_NOW(a_stall_needs_item, src_stall, stage.valid)
  `CSB_ASSERT_NEXT(a_drain_empties, dst_valid && !dst_stall && !stage.valid, !dst_valid)
  `CSB_ASSERT_NEXT(a_last_moves_on, stage.valid && take && stage.last, dst_valid && last)

endmodule

// ===== sv/csb_walker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sprite blitter raster walker
// Column and row counters, target position adders and the input register.
// ---------------------------------------------------------------------------
module csb_walker import csb_pkg::*; #(
  parameter int MAX_RECT = DEF_MAX_RECT
) (
  input  logic             clk,
  input  logic             rst,
  input  csb_cfg_t         cfg,
  input  logic             src_valid,
  output logic             src_stall,
  input  logic [PIX_W-1:0] pixel,
  input  logic             take,
  output csb_stage_t       stage
);

  localparam int CW = (MAX_RECT > 1) ? $clog2(MAX_RECT) : 1;
  localparam logic [SIZE_W-1:0] MAX_M1 = SIZE_W'(MAX_RECT - 1);

  logic [CW-1:0]           col_count;
  logic [CW-1:0]           row_count;
  logic [CW-1:0]           col_count_next;
  logic [CW-1:0]           row_count_next;
  logic                    s_valid;
  logic [PIX_W-1:0]        s_pixel;
  logic signed [POS_W-1:0] s_col;
  logic signed [POS_W-1:0] s_row;
  logic                    s_alpha_ok;
  logic                    s_last;

  logic [SIZE_W-1:0]       col_lim;
  logic [SIZE_W-1:0]       row_lim;
  logic                    end_col;
  logic                    end_row;
  logic                    accept;
  logic signed [POS_W-1:0] col_pos;
  logic signed [POS_W-1:0] row_pos;

  assign col_lim   = size_limit(cfg.rect_width, MAX_M1);
  assign row_lim   = size_limit(cfg.rect_height, MAX_M1);
  assign end_col   = SIZE_W'(col_count) >= col_lim;
  assign end_row   = SIZE_W'(row_count) >= row_lim;
  assign src_stall = s_valid && !take;
  assign accept    = src_valid && !src_stall;

  assign col_pos = POS_W'(cfg.dest_x) + POS_W'($signed({1'b0, col_count}));
  assign row_pos = POS_W'(cfg.dest_y) + POS_W'($signed({1'b0, row_count}));

  always_comb begin
    col_count_next = CW'(col_count + 1'b1);
    row_count_next = row_count;
    if (end_col) begin
      col_count_next = '0;
      row_count_next = end_row ? '0 : CW'(row_count + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      s_valid   <= 1'b0;
    end else begin
      if (accept) begin
        col_count <= col_count_next;
        row_count <= row_count_next;
        s_valid   <= 1'b1;
      end else if (take) begin
        s_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_pixel    <= pixel;
      s_col      <= col_pos;
      s_row      <= row_pos;
      s_alpha_ok <= !cfg.alpha_enable || ((pixel & ALPHA_MASK) != '0);
      s_last     <= end_col && end_row;
    end
  end

  always_comb begin
    stage.valid    = s_valid;
    stage.pixel    = s_pixel;
    stage.col      = s_col;
    stage.row      = s_row;
    stage.alpha_ok = s_alpha_ok;
    stage.last     = s_last;
  end

endmodule

// ===== sv/csb_mapper.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sprite blitter frame mapper
// Frame bounds test, address multiply-add and the result register.
// ---------------------------------------------------------------------------
module csb_mapper import csb_pkg::*; #(
  parameter int FRAME_W = DEF_FRAME_W,
  parameter int FRAME_H = DEF_FRAME_H
) (
  input  logic              clk,
  input  logic              rst,
  input  csb_stage_t        stage,
  output logic              take,
  output logic              dst_valid,
  input  logic              dst_stall,
  output logic              write_enable,
  output logic [ADDR_W-1:0] frame_addr,
  output logic [PIX_W-1:0]  pixel_out,
  output logic              last
);

  localparam logic signed [POS_W-1:0] FW_S = POS_W'(FRAME_W);
  localparam logic signed [POS_W-1:0] FH_S = POS_W'(FRAME_H);
  localparam logic [FWC_W-1:0]        FW_U = FWC_W'(FRAME_W);

  logic              in_frame;
  logic              load;
  logic [IDX_W-1:0]  row_idx;
  logic [IDX_W-1:0]  col_idx;
  logic [PROD_W-1:0] addr_full;

  assign take     = !dst_valid || !dst_stall;
  assign load     = stage.valid && take;
  assign in_frame = (stage.col >= 0) && (stage.col < FW_S) &&
                    (stage.row >= 0) && (stage.row < FH_S);
  assign row_idx  = stage.row[IDX_W-1:0];
  assign col_idx  = stage.col[IDX_W-1:0];

  always_comb begin
    addr_full = PROD_W'(row_idx) * PROD_W'(FW_U);
    addr_full = addr_full + PROD_W'(col_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else begin
      if (load) begin
        dst_valid <= 1'b1;
      end else if (!dst_stall) begin
        dst_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      write_enable <= in_frame && stage.alpha_ok;
      frame_addr   <= in_frame ? addr_full[ADDR_W-1:0] : '0;
      pixel_out    <= stage.pixel;
      last         <= stage.last;
    end
  end

endmodule
